// ===== rtl/core/dasf_pkg.sv =====
// Shared types and constants for the decimal ASCII sample formatter.
package dasf_pkg;

   localparam int SampleWidth = 16;
   localparam int ByteWidth   = 8;
   localparam int MaxDigits   = 5;
   localparam int DigitIdxW   = $clog2(MaxDigits + 1);

   // Reciprocal of ten: (x * 52429) >> 19 equals x / 10 for any 16-bit x.
   localparam logic [16:0] RECIP_TEN = 17'd52429;
   localparam int RecipShift = 19;

   localparam logic [ByteWidth-1:0] ASCII_ZERO  = 8'h30;
   localparam logic [ByteWidth-1:0] ASCII_SPACE = 8'h20;
   localparam logic [ByteWidth-1:0] ASCII_CR    = 8'h0D;
   localparam logic [ByteWidth-1:0] ASCII_LF    = 8'h0A;

   localparam logic [ByteWidth-1:0] VALUES_PER_LINE_RESET = 8'd10;

   // Which character the datapath loads into the output register.
   typedef enum logic [1:0] {
      SEL_DIGIT = 2'd0,
      SEL_SPACE = 2'd1,
      SEL_CR    = 2'd2,
      SEL_LF    = 2'd3
   } byte_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic         load;
      logic         divide;
      logic         emit;
      byte_sel_type sel;
      logic         emit_last;
   } dasf_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic quot_zero;
      logic last_digit;
      logic line_break;
      logic out_free;
   } dasf_stat_type;

endpackage

// ===== rtl/core/dasf_dp.sv =====
// Datapath: digit split, digit store, line counter, config register and output register.
module dasf_dp (
   input  logic                     clock,
   input  logic                     reset,
   input  dasf_pkg::dasf_cmd_type   cmd,
   output dasf_pkg::dasf_stat_type  stat,
   input  logic [15:0]              req_sample_value,
   input  logic                     req_last_in_block,
   input  logic                     csr_write_enable,
   input  logic [7:0]               csr_write_data,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output logic [7:0]               rsp_out_byte,
   output logic                     rsp_last_of_run
);
   import dasf_pkg::*;

   logic [SampleWidth-1:0] value_ff, value_in;
   logic [3:0]             digit_ff [MaxDigits];
   logic [DigitIdxW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [DigitIdxW-1:0]   rd_idx_ff, rd_idx_in;
   logic                   brk_ff, brk_in;
   logic [ByteWidth-1:0]   pos_ff, pos_in;
   logic [ByteWidth-1:0]   vpl_ff, vpl_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [ByteWidth-1:0]   rsp_byte_ff, rsp_byte_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic [SampleWidth+16:0] product;
   logic [SampleWidth-1:0]  quot;
   logic [SampleWidth-1:0]  rem_wide;
   logic [3:0]              digit;
   logic [ByteWidth-1:0]    next_pos;
   logic                    brk_now;
   logic                    out_free;

   // Divide by ten with a reciprocal multiply; the remainder is the next digit.
   assign product  = value_ff * RECIP_TEN;
   assign quot     = SampleWidth'(product >> RecipShift);
   assign rem_wide = value_ff - ((quot << 3) + (quot << 1));
   assign digit    = rem_wide[3:0];

   // Line break decision for the incoming transaction.
   assign next_pos = pos_ff + 8'd1;
   assign brk_now  = req_last_in_block || (next_pos == vpl_ff);

   // The output register may be loaded when empty or being drained.
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state of the working registers.
   always_comb begin
      value_in  = value_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_idx_in = rd_idx_ff;
      brk_in    = brk_ff;
      pos_in    = pos_ff;
      vpl_in    = csr_write_enable ? csr_write_data : vpl_ff;
      if (cmd.load) begin
         value_in  = req_sample_value;
         wr_ptr_in = '0;
         brk_in    = brk_now;
         pos_in    = brk_now ? 8'd0 : next_pos;
      end else if (cmd.divide) begin
         value_in  = quot;
         wr_ptr_in = wr_ptr_ff + 1'b1;
         rd_idx_in = wr_ptr_ff;
      end else if (cmd.emit && (cmd.sel == SEL_DIGIT) && (rd_idx_ff != '0)) begin
         rd_idx_in = rd_idx_ff - 1'b1;
      end
   end

   // Output register next state.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = cmd.emit_last;
         case (cmd.sel)
            SEL_DIGIT: rsp_byte_in = ASCII_ZERO + {4'd0, digit_ff[rd_idx_ff]};
            SEL_SPACE: rsp_byte_in = ASCII_SPACE;
            SEL_CR:    rsp_byte_in = ASCII_CR;
            SEL_LF:    rsp_byte_in = ASCII_LF;
            default:   rsp_byte_in = ASCII_SPACE;
         endcase
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         vpl_ff       <= VALUES_PER_LINE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         vpl_ff       <= vpl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      value_ff    <= value_in;
      wr_ptr_ff   <= wr_ptr_in;
      rd_idx_ff   <= rd_idx_in;
      brk_ff      <= brk_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Digit store, written least significant digit first.
   always_ff @(posedge clock) begin
      if (cmd.divide) begin
         digit_ff[wr_ptr_ff] <= digit;
      end
   end

   assign stat.quot_zero  = (quot == '0);
   assign stat.last_digit = (rd_idx_ff == '0);
   assign stat.line_break = brk_ff;
   assign stat.out_free   = out_free;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_last_of_run = rsp_last_ff;

endmodule

// ===== rtl/core/dasf_ctrl.sv =====
// Controller: sequences the digit split and the byte emission for one transaction.
module dasf_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  dasf_pkg::dasf_stat_type  stat,
   output dasf_pkg::dasf_cmd_type   cmd
);
   import dasf_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_DIVIDE = 6'b000010,
      ST_DIGIT  = 6'b000100,
      ST_SPACE  = 6'b001000,
      ST_CR     = 6'b010000,
      ST_LF     = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // Next state and commands.
   always_comb begin
      state_in      = state_ff;
      cmd.load      = 1'b0;
      cmd.divide    = 1'b0;
      cmd.emit      = 1'b0;
      cmd.sel       = SEL_DIGIT;
      cmd.emit_last = 1'b0;
      req_ready     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.divide = 1'b1;
            if (stat.quot_zero) begin
               state_in = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            cmd.sel = SEL_DIGIT;
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               if (stat.last_digit) begin
                  state_in = ST_SPACE;
               end
            end
         end
         ST_SPACE: begin
            cmd.sel       = SEL_SPACE;
            cmd.emit_last = !stat.line_break;
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = stat.line_break ? ST_CR : ST_IDLE;
            end
         end
         ST_CR: begin
            cmd.sel = SEL_CR;
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_LF;
            end
         end
         ST_LF: begin
            cmd.sel       = SEL_LF;
            cmd.emit_last = 1'b1;
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/decimal_ascii_sample_formatter.sv =====
// Decimal ASCII sample formatter: turns 16-bit samples into runs of ASCII bytes.
//
// Input channel (req_): one transaction carries an unsigned 16-bit sample and a
// flag that marks the last sample of a block. Output channel (rsp_): one
// transaction per ASCII byte; the decimal digits without leading zeros, a space,
// and CR LF when the line is full or the block ends. rsp_last_of_run marks the
// final byte of each sample's run.
// The CSR port writes values_per_line (reset 10) with no wait state; write it
// only while the block is idle.
// Timing: a sample is taken while the sequencer is idle, then split into digits
// at one digit per cycle by the reciprocal multiplier, then bytes leave the
// output register one per cycle while the receiver is ready. The next sample is
// taken once the last byte of the run sits in the output register.
// Reset clears the state machine, the line position and the output register and
// loads values_per_line with 10. When the receiver stalls, the held byte stays
// on rsp_ and the sequencer waits; no byte is lost.
module decimal_ascii_sample_formatter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_sample_value,
   input  logic        req_last_in_block,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_of_run,
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data
);
   import dasf_pkg::*;

   dasf_cmd_type  cmd;
   dasf_stat_type stat;

   // Sequencer.
   dasf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Datapath.
   dasf_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_sample_value  (req_sample_value),
      .req_last_in_block (req_last_in_block),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   // A taken sample keeps the input closed for at least the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted again right after a transaction");

   // A run always ends on a space or a line feed.
   a_run_end_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_of_run |->
         (rsp_out_byte == ASCII_SPACE) || (rsp_out_byte == ASCII_LF))
      else $error("run ended on an unexpected byte");

   // A line feed is always the final byte of its run.
   a_lf_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_out_byte == ASCII_LF) |-> rsp_last_of_run)
      else $error("line feed not marked as end of run");

endmodule
